>>> rtl/ptrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_pkg : shared types and constants of the periodic task release scheduler
// Sizes of the task table, field widths, operation and status codes, and the
// command record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ptrs_pkg;

   localparam int MAX_TASKS    = 8;
   localparam int MAX_PERIOD   = 255;
   localparam int RESULT_LIMIT = 8;

   localparam int SLOT_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_W = $clog2(MAX_TASKS + 1);
   localparam int NRES_W  = $clog2(RESULT_LIMIT + 1);

   localparam int OP_W     = 2;
   localparam int PERIOD_W = 8;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_TICK   = 2'd1,
      OP_RUN    = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_CREATE,
      CMD_TICK,
      CMD_RUN
   } cmd_kind_type;

   localparam logic [MODE_W-1:0] MODE_READY     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLOCKED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PERIOD = 2'd2;

   localparam logic KIND_CREATE = 1'b0;
   localparam logic KIND_RUN    = 1'b1;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [PERIOD_W-1:0]   period;
      logic [MODE_W-1:0]     mode;
      logic                  too_large;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

endpackage : ptrs_pkg
`default_nettype wire

>>> rtl/ptrs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_front : command front end
// Accepts requests, decodes the operation, checks the period range and hands
// a command record to the queue. Unused operation codes are dropped here.
// ----------------------------------------------------------------------------
module ptrs_front (
   input  wire logic                              start,
   input  wire logic [ptrs_pkg::OP_W-1:0]         req_operation,
   input  wire logic [ptrs_pkg::PERIOD_W-1:0]     req_period,
   input  wire logic [ptrs_pkg::MODE_W-1:0]       req_initial_state,
   input  wire logic                              queue_full,
   output logic                                   busy,
   output logic                                   push,
   output ptrs_pkg::cmd_type                      cmd
);

   logic accept;

   always_comb begin
      busy          = queue_full;
      accept        = start && !queue_full;
      push          = 1'b0;
      cmd.kind      = ptrs_pkg::CMD_TICK;
      cmd.period    = req_period;
      cmd.mode      = req_initial_state;
      cmd.too_large = (req_period > ptrs_pkg::PERIOD_W'(ptrs_pkg::MAX_PERIOD));
      case (ptrs_pkg::op_type'(req_operation))
         ptrs_pkg::OP_CREATE: begin
            cmd.kind = ptrs_pkg::CMD_CREATE;
            push     = accept;
         end
         ptrs_pkg::OP_TICK: begin
            cmd.kind = ptrs_pkg::CMD_TICK;
            push     = accept;
         end
         ptrs_pkg::OP_RUN: begin
            cmd.kind = ptrs_pkg::CMD_RUN;
            push     = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule : ptrs_front
`default_nettype wire

>>> rtl/ptrs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_queue : command queue
// A short first-in first-out buffer of command records between the front end
// and the back end.
// ----------------------------------------------------------------------------
module ptrs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ptrs_pkg::cmd_type wr_data,
   input  wire logic              pop,
   output ptrs_pkg::cmd_type      rd_data,
   output logic                   empty,
   output logic                   full
);

   ptrs_pkg::cmd_type            entry_ff [ptrs_pkg::QUEUE_DEPTH];
   logic [ptrs_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ptrs_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ptrs_pkg::QPTR_W:0]    fill_ff, fill_in;
   logic                         do_push;
   logic                         do_pop;

   always_comb begin
      empty     = (fill_ff == '0);
      full      = (fill_ff == (ptrs_pkg::QPTR_W + 1)'(ptrs_pkg::QUEUE_DEPTH));
      do_push   = push && !full;
      do_pop    = pop && !empty;
      rd_data   = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule : ptrs_queue
`default_nettype wire

>>> rtl/ptrs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_back : command back end
// Owns the task table. Creates tasks in one step and walks the table one slot
// per cycle for tick and run commands, producing registered results.
// ----------------------------------------------------------------------------
module ptrs_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                queue_empty,
   input  wire ptrs_pkg::cmd_type                   cmd,
   output logic                                     queue_pop,
   output logic                                     rsp_strobe,
   output logic                                     rsp_reply_kind,
   output logic [ptrs_pkg::STATUS_W-1:0]            rsp_status,
   output logic [ptrs_pkg::INDEX_W-1:0]             rsp_task_index,
   output logic                                     rsp_dispatched,
   output logic                                     rsp_last
);

   // Task table.
   logic [ptrs_pkg::PERIOD_W-1:0] period_mem [ptrs_pkg::MAX_TASKS];
   logic [ptrs_pkg::PERIOD_W-1:0] tick_mem   [ptrs_pkg::MAX_TASKS];
   logic [ptrs_pkg::MODE_W-1:0]   mode_mem   [ptrs_pkg::MAX_TASKS];

   ptrs_pkg::back_state_type       state_ff, state_in;
   ptrs_pkg::cmd_kind_type         kind_ff, kind_in;
   logic [ptrs_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [ptrs_pkg::COUNT_W-1:0]   walk_ff, walk_in;
   logic [ptrs_pkg::NRES_W-1:0]    found_ff, found_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [ptrs_pkg::SLOT_W-1:0]    pend_slot_ff, pend_slot_in;

   logic                           strobe_ff, strobe_in;
   logic                           reply_kind_ff, reply_kind_in;
   logic [ptrs_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [ptrs_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic                           disp_ff, disp_in;
   logic                           last_ff, last_in;

   logic [ptrs_pkg::SLOT_W-1:0]    slot;
   logic [ptrs_pkg::PERIOD_W-1:0]  rd_period;
   logic [ptrs_pkg::PERIOD_W-1:0]  rd_tick;
   logic [ptrs_pkg::MODE_W-1:0]    rd_mode;
   logic                           walking;

   logic                           wr_period_en;
   logic                           wr_tick_en;
   logic                           wr_mode_en;
   logic [ptrs_pkg::SLOT_W-1:0]    wr_slot;
   logic [ptrs_pkg::PERIOD_W-1:0]  wr_period;
   logic [ptrs_pkg::PERIOD_W-1:0]  wr_tick;
   logic [ptrs_pkg::MODE_W-1:0]    wr_mode;

   assign rsp_strobe     = strobe_ff;
   assign rsp_reply_kind = reply_kind_ff;
   assign rsp_status     = status_ff;
   assign rsp_task_index = index_ff;
   assign rsp_dispatched = disp_ff;
   assign rsp_last       = last_ff;

   always_comb begin
      slot      = walk_ff[ptrs_pkg::SLOT_W-1:0];
      rd_period = period_mem[slot];
      rd_tick   = tick_mem[slot];
      rd_mode   = mode_mem[slot];
      walking   = (walk_ff < count_ff) &&
                  ((kind_ff == ptrs_pkg::CMD_TICK) ||
                   (found_ff < ptrs_pkg::NRES_W'(ptrs_pkg::RESULT_LIMIT)));

      state_in      = state_ff;
      kind_in       = kind_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      queue_pop     = 1'b0;

      strobe_in     = 1'b0;
      reply_kind_in = reply_kind_ff;
      status_in     = status_ff;
      index_in      = index_ff;
      disp_in       = disp_ff;
      last_in       = last_ff;

      wr_period_en  = 1'b0;
      wr_tick_en    = 1'b0;
      wr_mode_en    = 1'b0;
      wr_slot       = slot;
      wr_period     = cmd.period;
      wr_tick       = rd_tick + 1'b1;
      wr_mode       = rd_mode;

      case (state_ff)
         ptrs_pkg::BACK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               case (cmd.kind)
                  ptrs_pkg::CMD_CREATE: begin
                     strobe_in     = 1'b1;
                     reply_kind_in = ptrs_pkg::KIND_CREATE;
                     disp_in       = 1'b0;
                     last_in       = 1'b1;
                     index_in      = '0;
                     if (count_ff >= ptrs_pkg::COUNT_W'(ptrs_pkg::MAX_TASKS)) begin
                        status_in = ptrs_pkg::STATUS_FULL;
                     end else if (cmd.too_large) begin
                        status_in = ptrs_pkg::STATUS_PERIOD;
                     end else begin
                        status_in    = ptrs_pkg::STATUS_OK;
                        index_in     = ptrs_pkg::INDEX_W'(count_ff);
                        wr_slot      = count_ff[ptrs_pkg::SLOT_W-1:0];
                        wr_period    = cmd.period;
                        wr_tick      = ptrs_pkg::PERIOD_W'(1);
                        wr_mode      = cmd.mode;
                        wr_period_en = 1'b1;
                        wr_tick_en   = 1'b1;
                        wr_mode_en   = 1'b1;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  ptrs_pkg::CMD_TICK,
                  ptrs_pkg::CMD_RUN: begin
                     state_in      = ptrs_pkg::BACK_WALK;
                     kind_in       = cmd.kind;
                     walk_in       = '0;
                     found_in      = '0;
                     pend_valid_in = 1'b0;
                  end
                  default: begin
                     state_in = ptrs_pkg::BACK_IDLE;
                  end
               endcase
            end
         end

         ptrs_pkg::BACK_WALK: begin
            if (walking) begin
               walk_in = walk_ff + 1'b1;
               if (kind_ff == ptrs_pkg::CMD_TICK) begin
                  if (rd_mode != ptrs_pkg::MODE_SUSPENDED) begin
                     wr_tick_en = 1'b1;
                     if (rd_tick >= rd_period) begin
                        wr_tick    = ptrs_pkg::PERIOD_W'(1);
                        wr_mode    = ptrs_pkg::MODE_READY;
                        wr_mode_en = 1'b1;
                     end
                  end
               end else if (rd_mode == ptrs_pkg::MODE_READY) begin
                  // A found task is held back one step so that the final
                  // dispatch of the walk can carry the last flag.
                  wr_mode       = ptrs_pkg::MODE_BLOCKED;
                  wr_mode_en    = 1'b1;
                  found_in      = found_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_slot_in  = slot;
                  if (pend_valid_ff) begin
                     strobe_in     = 1'b1;
                     reply_kind_in = ptrs_pkg::KIND_RUN;
                     status_in     = ptrs_pkg::STATUS_OK;
                     index_in      = ptrs_pkg::INDEX_W'(pend_slot_ff);
                     disp_in       = 1'b1;
                     last_in       = 1'b0;
                  end
               end
            end else begin
               state_in = ptrs_pkg::BACK_IDLE;
               if (kind_ff == ptrs_pkg::CMD_RUN) begin
                  strobe_in     = 1'b1;
                  reply_kind_in = ptrs_pkg::KIND_RUN;
                  status_in     = ptrs_pkg::STATUS_OK;
                  last_in       = 1'b1;
                  disp_in       = pend_valid_ff;
                  index_in      = pend_valid_ff ? ptrs_pkg::INDEX_W'(pend_slot_ff) : '0;
               end
            end
         end

         default: begin
            state_in = ptrs_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptrs_pkg::BACK_IDLE;
         kind_ff       <= ptrs_pkg::CMD_TICK;
         count_ff      <= '0;
         walk_ff       <= '0;
         found_ff      <= '0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kind_ff       <= kind_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff  <= pend_slot_in;
      reply_kind_ff <= reply_kind_in;
      status_ff     <= status_in;
      index_ff      <= index_in;
      disp_ff       <= disp_in;
      last_ff       <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_period_en) begin
         period_mem[wr_slot] <= wr_period;
      end
      if (wr_tick_en) begin
         tick_mem[wr_slot] <= wr_tick;
      end
      if (wr_mode_en) begin
         mode_mem[wr_slot] <= wr_mode;
      end
   end

endmodule : ptrs_back
`default_nettype wire

>>> rtl/periodic_task_release_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler : time-triggered cooperative task scheduler
// Keeps a table of periodic tasks, releases them on ticks and dispatches the
// ready ones in slot order when asked to run.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   ---------------------------------------
//   request   start high, busy low  req_operation, req_period,
//                                   req_initial_state
//   response  rsp_strobe, 1 cycle   rsp_reply_kind, rsp_status,
//                                   rsp_task_index, rsp_dispatched, rsp_last
//
// A create transaction is held in the command queue until the back end,
// once idle, takes it and registers its reply. Tick and run transactions
// occupy the back end while it takes the command from the queue, walks
// the task table one slot per cycle through a single read port, and then
// closes the walk; a run emits its dispatches during the walk, the last
// one on the closing step. The two-entry queue lets new requests be taken
// while the back end walks; busy rises only when that queue is full.
// Reset is synchronous and clears the task count and all control state; the
// table contents are not cleared, since only created slots are ever read.
// Responses cannot be stalled: each one is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [ptrs_pkg::OP_W-1:0]        req_operation,
   input  wire logic [ptrs_pkg::PERIOD_W-1:0]    req_period,
   input  wire logic [ptrs_pkg::MODE_W-1:0]      req_initial_state,
   output logic                                  rsp_strobe,
   output logic                                  rsp_reply_kind,
   output logic [ptrs_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ptrs_pkg::INDEX_W-1:0]          rsp_task_index,
   output logic                                  rsp_dispatched,
   output logic                                  rsp_last
);

   // Decoded command record from the front end into the queue.
   ptrs_pkg::cmd_type front_cmd;
   // Command at the head of the queue, seen by the back end.
   ptrs_pkg::cmd_type head_cmd;
   logic              front_push;
   logic              queue_full;
   logic              queue_empty;
   logic              back_pop;

   // The front end decodes each request; unused operation codes are
   // accepted and dropped without reaching the queue.
   ptrs_front u_front (
      .start             (start),
      .req_operation     (req_operation),
      .req_period        (req_period),
      .req_initial_state (req_initial_state),
      .queue_full        (queue_full),
      .busy              (busy),
      .push              (front_push),
      .cmd               (front_cmd)
   );

   // The queue decouples acceptance from the table walk.
   ptrs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_cmd),
      .pop     (back_pop),
      .rd_data (head_cmd),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   // The back end owns the task table and produces every response.
   ptrs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .cmd            (head_cmd),
      .queue_pop      (back_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_status     (rsp_status),
      .rsp_task_index (rsp_task_index),
      .rsp_dispatched (rsp_dispatched),
      .rsp_last       (rsp_last)
   );

endmodule : periodic_task_release_scheduler
`default_nettype wire

>>> tb/periodic_task_release_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_tb : self-checking bench of the task scheduler
// Drives create, tick, run and ignored commands through the start/busy port,
// keeps its own copy of the task table to work out every expected reply, and
// checks each strobed reply field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_tb;

   // Mode code three has no name in the package; the block stores it as given.
   localparam logic [ptrs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   // Generous fixed bound on the run, far above the slowest correct run.
   localparam int RUN_LIMIT_NS = 3_000_000;

   // Cycles to let pass after the last reply, so that a trailing tick or a
   // spurious extra reply has time to show up before the verdict.
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      ptrs_pkg::op_type              op;
      logic [ptrs_pkg::PERIOD_W-1:0] period;
      logic [ptrs_pkg::MODE_W-1:0]   mode;
   } sched_cmd_type;

   typedef struct packed {
      logic                          kind;
      logic [ptrs_pkg::STATUS_W-1:0] status;
      logic [ptrs_pkg::INDEX_W-1:0]  index;
      logic                          dispatched;
      logic                          last;
   } sched_reply_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [ptrs_pkg::OP_W-1:0]     req_operation = '0;
   logic [ptrs_pkg::PERIOD_W-1:0] req_period = '0;
   logic [ptrs_pkg::MODE_W-1:0]   req_initial_state = '0;
   logic                          rsp_strobe;
   logic                          rsp_reply_kind;
   logic [ptrs_pkg::STATUS_W-1:0] rsp_status;
   logic [ptrs_pkg::INDEX_W-1:0]  rsp_task_index;
   logic                          rsp_dispatched;
   logic                          rsp_last;

   // Commands waiting to be driven, and replies predicted but not yet seen.
   sched_cmd_type   cmd_backlog[$];
   sched_reply_type pending_replies[$];

   int cmds_issued = 0;
   int cmds_taken = 0;
   int error_count = 0;
   int idle_percent = 0;
   bit cmd_taken_last = 1'b0;
   sched_cmd_type next_cmd;

   // The bench's own copy of the task table.
   int                            task_total = 0;
   logic [ptrs_pkg::PERIOD_W-1:0] slot_period [ptrs_pkg::MAX_TASKS];
   logic [7:0]                    slot_count [ptrs_pkg::MAX_TASKS];
   logic [ptrs_pkg::MODE_W-1:0]   slot_mode [ptrs_pkg::MAX_TASKS];

   periodic_task_release_scheduler dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_period        (req_period),
      .req_initial_state (req_initial_state),
      .rsp_strobe        (rsp_strobe),
      .rsp_reply_kind    (rsp_reply_kind),
      .rsp_status        (rsp_status),
      .rsp_task_index    (rsp_task_index),
      .rsp_dispatched    (rsp_dispatched),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Every mismatch goes through here: one line printed, one error counted.
   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   // Applies one accepted command to the bench's task table and queues the
   // replies it must cause. Creates always reply once; ticks never reply;
   // runs reply once per dispatched task, or once with no dispatch.
   task automatic schedule_command(input sched_cmd_type c);
      sched_reply_type r;
      sched_reply_type held;
      bit              have_held;
      int              n;
      r = '0;
      held = '0;
      have_held = 1'b0;
      n = 0;
      case (c.op)
         ptrs_pkg::OP_CREATE: begin
            r.kind = ptrs_pkg::KIND_CREATE;
            r.last = 1'b1;
            // A full table wins over a period that is too large.
            if (task_total >= ptrs_pkg::MAX_TASKS) begin
               r.status = ptrs_pkg::STATUS_FULL;
            end else if (int'(c.period) > ptrs_pkg::MAX_PERIOD) begin
               r.status = ptrs_pkg::STATUS_PERIOD;
            end else begin
               slot_period[task_total] = c.period;
               slot_mode[task_total] = c.mode;
               slot_count[task_total] = 8'd1;
               r.status = ptrs_pkg::STATUS_OK;
               r.index = ptrs_pkg::INDEX_W'(task_total);
               task_total++;
            end
            pending_replies.push_back(r);
         end
         ptrs_pkg::OP_TICK: begin
            for (int i = 0; i < task_total; i++) begin
               if (slot_mode[i] != ptrs_pkg::MODE_SUSPENDED) begin
                  // A period of zero is reached on every tick; mode code three
                  // counts like a blocked task and is released the same way.
                  if (slot_count[i] >= slot_period[i]) begin
                     slot_mode[i] = ptrs_pkg::MODE_READY;
                     slot_count[i] = 8'd1;
                  end else begin
                     slot_count[i] = slot_count[i] + 8'd1;
                  end
               end
            end
         end
         ptrs_pkg::OP_RUN: begin
            // Each reply is held back one step so that the final one can be
            // marked last before it is queued.
            for (int i = 0; i < task_total; i++) begin
               if (n < ptrs_pkg::RESULT_LIMIT && slot_mode[i] == ptrs_pkg::MODE_READY) begin
                  slot_mode[i] = ptrs_pkg::MODE_BLOCKED;
                  if (have_held) begin
                     pending_replies.push_back(held);
                  end
                  held = '0;
                  held.kind = ptrs_pkg::KIND_RUN;
                  held.status = ptrs_pkg::STATUS_OK;
                  held.index = ptrs_pkg::INDEX_W'(i);
                  held.dispatched = 1'b1;
                  have_held = 1'b1;
                  n++;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               pending_replies.push_back(held);
            end else begin
               r.kind = ptrs_pkg::KIND_RUN;
               r.last = 1'b1;
               pending_replies.push_back(r);
            end
         end
         default: begin
            // Operation code three is taken by the handshake and otherwise
            // ignored: no reply and no change to the table.
         end
      endcase
   endtask

   // Acceptance: a command is taken at a rising edge with start high and busy
   // low. The prediction is made from the values on the request ports.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         schedule_command(sched_cmd_type'{op: ptrs_pkg::op_type'(req_operation),
                                          period: req_period,
                                          mode: req_initial_state});
         cmds_taken++;
         cmd_taken_last = 1'b1;
      end else begin
         cmd_taken_last = 1'b0;
      end
   end

   // Driver: inputs move only at the falling edge. A command that was not yet
   // taken stays on the ports; otherwise the next one is offered, unless the
   // sender idles this cycle. start gets a single assignment per edge, so a
   // back-to-back transaction simply keeps it high.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || cmd_taken_last) begin
         if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= idle_percent) begin
            next_cmd = cmd_backlog.pop_front();
            req_operation <= next_cmd.op;
            req_period <= next_cmd.period;
            req_initial_state <= next_cmd.mode;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed reply is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply kind %0d index %0d",
                                      rsp_reply_kind, rsp_task_index));
         end else begin
            check_field("reply_kind", rsp_reply_kind, pending_replies[0].kind);
            check_field("status", rsp_status, pending_replies[0].status);
            check_field("task_index", rsp_task_index, pending_replies[0].index);
            check_field("dispatched", rsp_dispatched, pending_replies[0].dispatched);
            check_field("last", rsp_last, pending_replies[0].last);
            void'(pending_replies.pop_front());
         end
      end
   end

   task automatic queue_command(input ptrs_pkg::op_type op, input int period,
                                input int mode);
      cmd_backlog.push_back(sched_cmd_type'{op: op,
                                            period: ptrs_pkg::PERIOD_W'(period),
                                            mode: ptrs_pkg::MODE_W'(mode)});
      cmds_issued++;
   endtask

   // Waits until every queued command has been taken and every expected
   // reply has arrived. The sender has nothing to offer meanwhile, so this
   // is also the point where it pauses for the block to catch up.
   task automatic settle;
      while (cmds_taken != cmds_issued) @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // One random phase. Ticks dominate so that long periods still come due;
   // creates fill the rest of the table early and are rejected afterwards.
   // Ignored operations are sprinkled in but do not count toward the quota.
   task automatic random_phase(input int idle, input int quota);
      int done;
      int pick;
      int period;
      done = 0;
      idle_percent = idle;
      while (done < quota) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0) begin
            period = $urandom_range(0, 255);
         end else begin
            period = $urandom_range(0, 6);
         end
         if (pick < 7) begin
            queue_command(ptrs_pkg::OP_CREATE, period, $urandom_range(0, 3));
            done++;
         end else if (pick < 10) begin
            queue_command(ptrs_pkg::OP_IGNORE, period, $urandom_range(0, 3));
         end else if (pick < 68) begin
            queue_command(ptrs_pkg::OP_TICK, period, $urandom_range(0, 3));
            done++;
         end else begin
            queue_command(ptrs_pkg::OP_RUN, period, $urandom_range(0, 3));
            done++;
         end
      end
      settle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening with no sender idling.
      idle_percent = 0;
      queue_command(ptrs_pkg::OP_RUN, 0, 0);             // empty table: no dispatch
      queue_command(ptrs_pkg::OP_TICK, 0, 0);            // empty table: nothing moves
      queue_command(ptrs_pkg::OP_IGNORE, 255, 3);        // operation code three
      queue_command(ptrs_pkg::OP_CREATE, 0, ptrs_pkg::MODE_READY);     // period zero
      queue_command(ptrs_pkg::OP_CREATE, 255, ptrs_pkg::MODE_BLOCKED); // longest period
      queue_command(ptrs_pkg::OP_CREATE, 1, ptrs_pkg::MODE_SUSPENDED); // never moves
      queue_command(ptrs_pkg::OP_CREATE, 2, MODE_SPARE);               // mode code three
      queue_command(ptrs_pkg::OP_RUN, 0, 0);             // dispatches slot zero only
      queue_command(ptrs_pkg::OP_RUN, 0, 0);             // nothing ready any more
      queue_command(ptrs_pkg::OP_TICK, 0, 0);
      queue_command(ptrs_pkg::OP_TICK, 0, 0);            // mode three task comes due
      queue_command(ptrs_pkg::OP_RUN, 0, 0);             // two dispatches in a row
      queue_command(ptrs_pkg::OP_CREATE, 1, ptrs_pkg::MODE_READY);
      queue_command(ptrs_pkg::OP_CREATE, 3, ptrs_pkg::MODE_BLOCKED);
      queue_command(ptrs_pkg::OP_CREATE, 0, MODE_SPARE);
      queue_command(ptrs_pkg::OP_CREATE, 2, ptrs_pkg::MODE_READY);     // table now full
      queue_command(ptrs_pkg::OP_CREATE, 255, MODE_SPARE);   // rejected: table full
      queue_command(ptrs_pkg::OP_CREATE, 0, ptrs_pkg::MODE_READY);     // rejected: full
      queue_command(ptrs_pkg::OP_RUN, 0, 0);
      queue_command(ptrs_pkg::OP_TICK, 0, 0);
      queue_command(ptrs_pkg::OP_RUN, 0, 0);
      queue_command(ptrs_pkg::OP_TICK, 0, 0);
      queue_command(ptrs_pkg::OP_TICK, 0, 0);
      queue_command(ptrs_pkg::OP_RUN, 0, 0);
      settle();

      // Random phases with changing sender idling; each one ends with the
      // sender waiting until every reply is in.
      random_phase(0, 100);
      random_phase(52, 100);
      random_phase(34, 100);
      random_phase(0, 100);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("TIMEOUT: %0d of %0d transactions taken, %0d replies outstanding",
               cmds_taken, cmds_issued, pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/ptrs_pkg.sv
rtl/ptrs_front.sv
rtl/ptrs_queue.sv
rtl/ptrs_back.sv
rtl/periodic_task_release_scheduler.sv
tb/periodic_task_release_scheduler_tb.sv
